[design/glyph_quad_text_layout_top_macros.svh]
// Assertion macros used by the glyph quad layout checker.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_TOP_MACROS_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GQTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glyph layout check failed");

// Next-cycle implication, disabled during reset.
`define GQTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glyph layout check failed");

`endif

[design/gqtl_pkg.sv]
// Shared types and constants of the glyph quad text layout block.
package gqtl_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int SIZE_SLOTS_DEF  = 4;
	localparam int PEN_BITS_DEF    = 20;

	localparam logic [1:0] OP_LOAD_GLYPH   = 2'd0;
	localparam logic [1:0] OP_LOAD_METRICS = 2'd1;
	localparam logic [1:0] OP_START        = 2'd2;
	localparam logic [1:0] OP_PLACE        = 2'd3;

	localparam logic [7:0] CODE_SPACE   = 8'd32;
	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam int         TAB_SHIFT    = 2;  // tab = four widths

	localparam logic [2:0] KIND_START   = 3'd0;
	localparam logic [2:0] KIND_SPACE   = 3'd1;
	localparam logic [2:0] KIND_TAB     = 3'd2;
	localparam logic [2:0] KIND_NEWLINE = 3'd3;
	localparam logic [2:0] KIND_GLYPH   = 3'd4;

	localparam int         APB_ADDR_BITS   = 4;
	localparam logic [1:0] REG_FONT_SIZE   = 2'd0;
	localparam logic [1:0] REG_TEX_WIDTH   = 2'd1;
	localparam logic [1:0] REG_TEX_HEIGHT  = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int UV_LANES = 4;
	localparam int LANE_UL  = 0;
	localparam int LANE_UR  = 1;
	localparam int LANE_VT  = 2;
	localparam int LANE_VB  = 3;

	localparam logic [16:0] UV_ONE      = 17'h10000;
	localparam logic [2:0]  LAST_CORNER = 3'd5;
	localparam int          OUT_XY_BITS = 20;

	typedef struct packed {
		logic [2:0]  font_size;
		logic [15:0] tex_width;
		logic [15:0] tex_height;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] top;
		logic [15:0] bottom;
	} q_entry_t;

	typedef struct packed {
		logic                 valid;
		logic [QCNT_BITS-1:0] count;
	} q_status_t;

endpackage

[design/glyph_quad_text_layout_top.sv]
// Top level of the glyph quad text layout block: configuration registers and wiring.
//
// Input channel (in_valid / in_stall): one request per accepted cycle. Load glyph and
// load line metrics write the tables and produce nothing; start clears the pen; place
// character either moves the pen (space, tab, newline) or emits one textured quad.
// Output channel (out_valid / out_stall): six vertex results per visible character,
// corners 0..5, last_vertex set on corner 5.
// Loads are done in the front end. A visible character is taken from the queue, runs
// through the four-lane u,v divider (two quotient bits per cycle), then leaves the
// output register one vertex per cycle while the receiver does not stall; the back
// end takes nothing more from the queue meanwhile. Pen moves and start are done as
// the back end takes them from the queue.
// A four-entry queue separates front and back; the front keeps accepting loads and
// short requests while the back emits; it stalls only when queue plus stage 1 fill it.
// When the receiver stalls, the held vertex stays put and the back end waits.
// Reset clears the pen, the queue and the registers (font_size 1, texture sizes 1);
// table contents are undefined until loaded. APB port: registers at byte 0, 4, 8.
module glyph_quad_text_layout_top #(
	parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF,
	parameter int SIZE_SLOTS  = gqtl_pkg::SIZE_SLOTS_DEF,
	parameter int PEN_BITS    = gqtl_pkg::PEN_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gqtl_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         operation,
	input  logic [2:0]                         size_slot,
	input  logic [7:0]                         char_code,
	input  logic [15:0]                        glyph_left,
	input  logic [15:0]                        glyph_right,
	input  logic [15:0]                        line_top,
	input  logic [15:0]                        line_bottom,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [19:0]                        vert_x,
	output logic [19:0]                        vert_y,
	output logic [16:0]                        tex_u,
	output logic [16:0]                        tex_v,
	output logic [2:0]                         corner_index,
	output logic                               last_vertex
);

	gqtl_pkg::cfg_t      cfg_q;
	gqtl_pkg::q_status_t q_status;
	gqtl_pkg::q_entry_t  push_entry;
	gqtl_pkg::q_entry_t  head;
	logic                push;
	logic                pop;
	logic                cfg_we;
	logic [1:0]          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_size  <= 3'd1;
			cfg_q.tex_width  <= 16'd1;
			cfg_q.tex_height <= 16'd1;
		end else if (cfg_we) begin
			unique case (reg_idx)
				gqtl_pkg::REG_FONT_SIZE:  cfg_q.font_size  <= pwdata[2:0];
				gqtl_pkg::REG_TEX_WIDTH:  cfg_q.tex_width  <= pwdata[15:0];
				gqtl_pkg::REG_TEX_HEIGHT: cfg_q.tex_height <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			gqtl_pkg::REG_FONT_SIZE:  prdata = {29'd0, cfg_q.font_size};
			gqtl_pkg::REG_TEX_WIDTH:  prdata = {16'd0, cfg_q.tex_width};
			gqtl_pkg::REG_TEX_HEIGHT: prdata = {16'd0, cfg_q.tex_height};
			default:                  prdata = 32'd0;
		endcase
	end

	gqtl_front #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.SIZE_SLOTS  (SIZE_SLOTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.size_slot   (size_slot),
		.char_code   (char_code),
		.glyph_left  (glyph_left),
		.glyph_right (glyph_right),
		.line_top    (line_top),
		.line_bottom (line_bottom),
		.cfg         (cfg_q),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	gqtl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	gqtl_back #(
		.PEN_BITS (PEN_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head         (head),
		.pop          (pop),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.corner_index (corner_index),
		.last_vertex  (last_vertex)
	);

endmodule

[design/gqtl_front.sv]
// Front end: accepts requests, keeps the glyph and metric tables, classifies placements.
module gqtl_front #(
	parameter int GLYPH_COUNT = gqtl_pkg::GLYPH_COUNT_DEF,
	parameter int SIZE_SLOTS  = gqtl_pkg::SIZE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic [2:0]          size_slot,
	input  logic [7:0]          char_code,
	input  logic [15:0]         glyph_left,
	input  logic [15:0]         glyph_right,
	input  logic [15:0]         line_top,
	input  logic [15:0]         line_bottom,
	input  gqtl_pkg::cfg_t      cfg,
	input  gqtl_pkg::q_status_t q_status,
	output logic                push,
	output gqtl_pkg::q_entry_t  push_entry
);

	localparam int DEPTH = SIZE_SLOTS * GLYPH_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (SIZE_SLOTS > 1) ? $clog2(SIZE_SLOTS) : 1;

	logic [31:0]   mem [DEPTH];
	logic [15:0]   top_q    [SIZE_SLOTS];
	logic [15:0]   bottom_q [SIZE_SLOTS];

	logic          accept;
	logic          slot_ok;
	logic          code_ok;
	logic [SW-1:0] load_slot;
	logic [SW-1:0] place_slot;
	logic [SW-1:0] addr_slot;
	logic [AW-1:0] addr;
	logic          glyph_we;
	logic          metric_we;
	logic          push_s0;
	logic [2:0]    kind_s0;

	logic          valid_s1;
	logic [2:0]    kind_s1;
	logic [15:0]   top_s1;
	logic [15:0]   bottom_s1;
	logic [31:0]   edges_s1;

	// Room is reserved for the request sitting in stage 1.
	assign in_stall = (32'(q_status.count) + 32'(valid_s1)) >= gqtl_pkg::QUEUE_DEPTH;
	assign accept   = in_valid && !in_stall;

	assign slot_ok = (size_slot != 3'd0) && (32'(size_slot) <= SIZE_SLOTS);
	assign code_ok = 32'(char_code) < GLYPH_COUNT;
	assign load_slot = SW'(32'(size_slot) - 32'd1);

	always_comb begin
		priority if (cfg.font_size == 3'd0) begin
			place_slot = '0;
		end else if (32'(cfg.font_size) > SIZE_SLOTS) begin
			place_slot = SW'(SIZE_SLOTS - 1);
		end else begin
			place_slot = SW'(32'(cfg.font_size) - 32'd1);
		end
	end

	assign addr_slot = (operation == gqtl_pkg::OP_LOAD_GLYPH) ? load_slot : place_slot;
	assign addr      = AW'(32'(addr_slot) * GLYPH_COUNT + 32'(char_code));

	assign glyph_we  = accept && (operation == gqtl_pkg::OP_LOAD_GLYPH) && slot_ok && code_ok;
	assign metric_we = accept && (operation == gqtl_pkg::OP_LOAD_METRICS) && slot_ok;

	always_comb begin
		priority if (operation == gqtl_pkg::OP_START) begin
			kind_s0 = gqtl_pkg::KIND_START;
		end else if (char_code == gqtl_pkg::CODE_SPACE) begin
			kind_s0 = gqtl_pkg::KIND_SPACE;
		end else if (char_code == gqtl_pkg::CODE_TAB) begin
			kind_s0 = gqtl_pkg::KIND_TAB;
		end else if (char_code == gqtl_pkg::CODE_NEWLINE) begin
			kind_s0 = gqtl_pkg::KIND_NEWLINE;
		end else begin
			kind_s0 = gqtl_pkg::KIND_GLYPH;
		end
	end

	assign push_s0 = accept && ((operation == gqtl_pkg::OP_START) ||
		((operation == gqtl_pkg::OP_PLACE) && code_ok));

	always_ff @(posedge clk) begin
		if (glyph_we) begin
			mem[addr] <= {glyph_right, glyph_left};
		end
		edges_s1 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (metric_we) begin
			top_q[load_slot]    <= line_top;
			bottom_q[load_slot] <= line_bottom;
		end
		kind_s1   <= kind_s0;
		top_s1    <= top_q[place_slot];
		bottom_s1 <= bottom_q[place_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= push_s0;
		end
	end

	assign push              = valid_s1;
	assign push_entry.kind   = kind_s1;
	assign push_entry.left   = edges_s1[15:0];
	assign push_entry.right  = edges_s1[31:16];
	assign push_entry.top    = top_s1;
	assign push_entry.bottom = bottom_s1;

endmodule

[design/gqtl_queue.sv]
// Short FIFO between the front end and the back end.
module gqtl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gqtl_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output gqtl_pkg::q_entry_t  head,
	output gqtl_pkg::q_status_t status
);

	gqtl_pkg::q_entry_t               entries_q [gqtl_pkg::QUEUE_DEPTH];
	logic [gqtl_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [gqtl_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [gqtl_pkg::QCNT_BITS-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// The front end never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign status.valid = count_q != '0;
	assign status.count = count_q;

endmodule

[design/gqtl_div.sv]
// Four-lane texel-to-0.16 divider, two restoring steps per cycle per lane.
module gqtl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] coord   [gqtl_pkg::UV_LANES],
	input  logic [15:0] divisor [gqtl_pkg::UV_LANES],
	output logic        done,
	output logic [16:0] quo     [gqtl_pkg::UV_LANES]
);

	localparam int STEPS      = 2;
	localparam int DIV_CYCLES = 16 / STEPS;
	localparam int CW         = $clog2(DIV_CYCLES);

	logic [15:0]   dsr_q [gqtl_pkg::UV_LANES];
	logic [16:0]   rem_q [gqtl_pkg::UV_LANES];
	logic [15:0]   quo_q [gqtl_pkg::UV_LANES];
	logic          sat_q [gqtl_pkg::UV_LANES];
	logic [16:0]   rem_d [gqtl_pkg::UV_LANES];
	logic [15:0]   quo_d [gqtl_pkg::UV_LANES];
	logic [15:0]   dsr_in [gqtl_pkg::UV_LANES];
	logic          busy_q;
	logic [CW-1:0] cnt_q;

	assign done = busy_q && (cnt_q == CW'(DIV_CYCLES - 1));

	// Unless a lane saturates, its remainder stays below the divisor, so bit 16 is clear between steps.
	always_comb begin
		for (int i = 0; i < gqtl_pkg::UV_LANES; i++) begin
			dsr_in[i] = (divisor[i] == 16'd0) ? 16'd1 : divisor[i];
			rem_d[i]  = rem_q[i];
			quo_d[i]  = quo_q[i];
			for (int k = 0; k < STEPS; k++) begin
				if ({rem_d[i][15:0], 1'b0} >= {1'b0, dsr_q[i]}) begin
					rem_d[i] = {rem_d[i][15:0], 1'b0} - {1'b0, dsr_q[i]};
					quo_d[i] = {quo_d[i][14:0], 1'b1};
				end else begin
					rem_d[i] = {rem_d[i][15:0], 1'b0};
					quo_d[i] = {quo_d[i][14:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < gqtl_pkg::UV_LANES; i++) begin
			if (start) begin
				dsr_q[i] <= dsr_in[i];
				rem_q[i] <= {1'b0, coord[i]};
				quo_q[i] <= '0;
				sat_q[i] <= coord[i] >= dsr_in[i];  // u of one or more saturates
			end else if (busy_q) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < gqtl_pkg::UV_LANES; i++) begin
			quo[i] = sat_q[i] ? gqtl_pkg::UV_ONE : {1'b0, quo_q[i]};
		end
	end

endmodule

[design/gqtl_back.sv]
// Back end: pen update, texture coordinates and six-vertex quad output.
module gqtl_back #(
	parameter int PEN_BITS = gqtl_pkg::PEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gqtl_pkg::q_status_t q_status,
	input  gqtl_pkg::q_entry_t  head,
	output logic                pop,
	input  gqtl_pkg::cfg_t      cfg,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [19:0]         vert_x,
	output logic [19:0]         vert_y,
	output logic [16:0]         tex_u,
	output logic [16:0]         tex_v,
	output logic [2:0]          corner_index,
	output logic                last_vertex
);

	localparam int SUMW = PEN_BITS + 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [2:0]            corner_q;
	logic [PEN_BITS-1:0]   pen_x_q;
	logic [PEN_BITS-1:0]   pen_y_q;
	logic [PEN_BITS-1:0]   x0_q;
	logic [PEN_BITS-1:0]   x1_q;
	logic [PEN_BITS-1:0]   y0_q;
	logic [PEN_BITS-1:0]   y1_q;

	logic signed [SUMW-1:0] w_ext;
	logic signed [SUMW-1:0] h_ext;
	logic signed [SUMW-1:0] sum_x;
	logic signed [SUMW-1:0] sum_y;
	logic [PEN_BITS-1:0]    sat_x;
	logic [PEN_BITS-1:0]    sat_y;

	logic                  div_start;
	logic                  div_done;
	logic [15:0]           div_coord [gqtl_pkg::UV_LANES];
	logic [15:0]           div_size  [gqtl_pkg::UV_LANES];
	logic [16:0]           div_quo   [gqtl_pkg::UV_LANES];

	logic                  load;
	logic                  use_x1;
	logic                  use_y1;
	logic [PEN_BITS-1:0]   sel_x;
	logic [PEN_BITS-1:0]   sel_y;

	logic                  out_valid_q;
	logic [19:0]           vert_x_q;
	logic [19:0]           vert_y_q;
	logic [16:0]           tex_u_q;
	logic [16:0]           tex_v_q;
	logic [2:0]            corner_out_q;

	function automatic logic [PEN_BITS-1:0] sat_pen(input logic signed [SUMW-1:0] v);
		if (v[SUMW-1]) begin
			return '0;
		end else if (|v[SUMW-2:PEN_BITS]) begin
			return '1;
		end
		return v[PEN_BITS-1:0];
	endfunction

	// Widths and heights are signed edge differences.
	assign w_ext = $signed({{(SUMW-16){1'b0}}, head.right}) -
		$signed({{(SUMW-16){1'b0}}, head.left});
	assign h_ext = $signed({{(SUMW-16){1'b0}}, head.bottom}) -
		$signed({{(SUMW-16){1'b0}}, head.top});

	assign sum_x = $signed({{(SUMW-PEN_BITS){1'b0}}, pen_x_q}) +
		((head.kind == gqtl_pkg::KIND_TAB) ? (w_ext <<< gqtl_pkg::TAB_SHIFT) : w_ext);
	assign sum_y = $signed({{(SUMW-PEN_BITS){1'b0}}, pen_y_q}) + h_ext;
	assign sat_x = sat_pen(sum_x);
	assign sat_y = sat_pen(sum_y);

	assign pop       = (state_q == ST_IDLE) && q_status.valid;
	assign div_start = pop && (head.kind == gqtl_pkg::KIND_GLYPH);

	assign div_coord[gqtl_pkg::LANE_UL] = head.left;
	assign div_coord[gqtl_pkg::LANE_UR] = head.right;
	assign div_coord[gqtl_pkg::LANE_VT] = head.top;
	assign div_coord[gqtl_pkg::LANE_VB] = head.bottom;
	assign div_size[gqtl_pkg::LANE_UL]  = cfg.tex_width;
	assign div_size[gqtl_pkg::LANE_UR]  = cfg.tex_width;
	assign div_size[gqtl_pkg::LANE_VT]  = cfg.tex_height;
	assign div_size[gqtl_pkg::LANE_VB]  = cfg.tex_height;

	gqtl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.coord   (div_coord),
		.divisor (div_size),
		.done    (div_done),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= '0;
			pen_x_q  <= '0;
			pen_y_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							gqtl_pkg::KIND_START: begin
								pen_x_q <= '0;
								pen_y_q <= '0;
							end
							gqtl_pkg::KIND_SPACE, gqtl_pkg::KIND_TAB: begin
								pen_x_q <= sat_x;
							end
							gqtl_pkg::KIND_NEWLINE: begin
								pen_x_q <= '0;
								pen_y_q <= sat_y;
							end
							gqtl_pkg::KIND_GLYPH: begin
								pen_x_q <= sat_x;
								state_q <= ST_DIV;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						corner_q <= '0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						corner_q <= corner_q + 3'd1;
						if (corner_q == gqtl_pkg::LAST_CORNER) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			x0_q <= pen_x_q;
			y0_q <= pen_y_q;
			x1_q <= sat_x;
			y1_q <= sat_y;
		end
	end

	// Corners: 0 (x0,y0) 1 (x1,y0) 2 (x1,y1) 3 (x0,y0) 4 (x1,y1) 5 (x0,y1).
	always_comb begin
		unique case (corner_q)
			3'd1:    begin use_x1 = 1'b1; use_y1 = 1'b0; end
			3'd2:    begin use_x1 = 1'b1; use_y1 = 1'b1; end
			3'd4:    begin use_x1 = 1'b1; use_y1 = 1'b1; end
			3'd5:    begin use_x1 = 1'b0; use_y1 = 1'b1; end
			default: begin use_x1 = 1'b0; use_y1 = 1'b0; end
		endcase
	end

	assign sel_x = use_x1 ? x1_q : x0_q;
	assign sel_y = use_y1 ? y1_q : y0_q;
	assign load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vert_x_q     <= gqtl_pkg::OUT_XY_BITS'(32'(sel_x));
			vert_y_q     <= gqtl_pkg::OUT_XY_BITS'(32'(sel_y));
			tex_u_q      <= use_x1 ? div_quo[gqtl_pkg::LANE_UR] : div_quo[gqtl_pkg::LANE_UL];
			tex_v_q      <= use_y1 ? div_quo[gqtl_pkg::LANE_VB] : div_quo[gqtl_pkg::LANE_VT];
			corner_out_q <= corner_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign vert_x       = vert_x_q;
	assign vert_y       = vert_y_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;
	assign corner_index = corner_out_q;
	assign last_vertex  = corner_out_q == gqtl_pkg::LAST_CORNER;

endmodule

[design/gqtl_checker.sv]
// Port-level checks of the glyph quad text layout block, bound to the top level.
`include "glyph_quad_text_layout_top_macros.svh"

module gqtl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_stall,
	input logic [19:0] vert_x,
	input logic [19:0] vert_y,
	input logic [16:0] tex_u,
	input logic [16:0] tex_v,
	input logic [2:0]  corner_index,
	input logic        last_vertex
);

	`GQTL_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({vert_x, vert_y, tex_u, tex_v, corner_index, last_vertex}))

	`GQTL_ASSERT_IMP(a_last_flag, clk, arst_n, out_valid, last_vertex == (corner_index == gqtl_pkg::LAST_CORNER))

	// Corners of a quad leave back to back once the receiver takes them.
	`GQTL_ASSERT_NXT(a_corner_seq, clk, arst_n, out_valid && !out_stall && !last_vertex, out_valid && (corner_index == $past(corner_index) + 3'd1))

	`GQTL_ASSERT_IMP(a_uv_sat, clk, arst_n, out_valid, (!tex_u[16] || (tex_u[15:0] == 16'd0)) && (!tex_v[16] || (tex_v[15:0] == 16'd0)))

	`GQTL_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind glyph_quad_text_layout_top gqtl_checker u_gqtl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.vert_x       (vert_x),
	.vert_y       (vert_y),
	.tex_u        (tex_u),
	.tex_v        (tex_v),
	.corner_index (corner_index),
	.last_vertex  (last_vertex)
);
